>>> design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and codes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;
	localparam int NUM_PAGES  = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = NUM_PAGES / WORD_BITS;
	localparam int WADDR_W    = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int CHUNK      = 8;
	localparam int CHUNK_W    = $clog2(CHUNK);
	localparam int PAGE_W     = 12;
	localparam int CNT_W      = 13;

	localparam logic [CNT_W-1:0] MAX_PAGES = CNT_W'(NUM_PAGES);

	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_FREE    = 2'd1;
	localparam logic [1:0] FUNC_RESERVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CNT  = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;

	typedef struct packed {
		logic             found;
		logic             at_lim;
		logic [CNT_W-1:0] run;
		logic [CNT_W-1:0] run_end;
	} scan_res_t;
endpackage

>>> design/bpa_run_scan.sv
// ----------------------------------------------------------------------------
// bpa_run_scan
// Free-run counter over one chunk of the map: extends the running run length
// and flags a hit or the end of the managed range.
// ----------------------------------------------------------------------------
module bpa_run_scan import bpa_pkg::*; (
	input  logic [CHUNK-1:0] bits,
	input  logic [CNT_W-1:0] chunk_base,
	input  logic [CNT_W-1:0] lim,
	input  logic [CNT_W-1:0] count,
	input  logic [CNT_W-1:0] run_in,
	output scan_res_t        res
);
	always_comb begin
		logic [CNT_W-1:0] p;
		res = '0;
		res.run = run_in;
		for (int b = 0; b < CHUNK; b++) begin
			p = chunk_base + CNT_W'(b);
			if (!res.found && !res.at_lim) begin
				if (p >= lim) begin
					res.at_lim = 1'b1;
				end else begin
					res.run = bits[b] ? '0 : res.run + 1'b1;
					if (res.run == count) begin
						res.found   = 1'b1;
						res.run_end = p + 1'b1;
					end
				end
			end
		end
	end
endmodule

>>> design/bpa_mask_gen.sv
// ----------------------------------------------------------------------------
// bpa_mask_gen
// Bit mask of the pages of one map word that fall inside [rng_start, rng_end).
// ----------------------------------------------------------------------------
module bpa_mask_gen import bpa_pkg::*; (
	input  logic [WADDR_W-1:0]   word_idx,
	input  logic [CNT_W-1:0]     rng_start,
	input  logic [CNT_W-1:0]     rng_end,
	output logic [WORD_BITS-1:0] mask
);
	always_comb begin
		logic [CNT_W-1:0] p;
		for (int b = 0; b < WORD_BITS; b++) begin
			p = {1'b0, word_idx, BIT_W'(b)};
			mask[b] = (p >= rng_start) && (p < rng_end);
		end
	end
endmodule

>>> design/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a one-bit-per-page used map.
//
//   channel  handshake           word
//   cfg      psel/penable/pwrite managed_pages at address 0
//   req      req_valid/req_ready func, start_page, req_pages
//   rsp      rsp_valid/rsp_ready status, base_page
//
// Allocate scans 8 pages a cycle, pausing in S_RD to read each 32-page word
// through the single map read port; the found range is then marked word by
// word (S_MRD, S_MWR), as free/reserve mark each word they touch.
// After reset the map reads as all used (per-word valid bits), no sweep.
// One request at a time; req_ready is low while busy or a response waits.
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        func,
	input  logic [PAGE_W-1:0] start_page,
	input  logic [CNT_W-1:0]  req_pages,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        status,
	output logic [PAGE_W-1:0] base_page
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_MRD  = 3'd3;
	localparam logic [2:0] S_MWR  = 3'd4;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     managed_q;
	logic [CNT_W-1:0]     lim;
	logic [CNT_W-1:0]     pg_q, run_q, cnt_q;
	logic [CNT_W-1:0]     rng_start_q, rng_end_q;
	logic [WADDR_W-1:0]   wptr_q, rd_addr;
	logic                 set_q;
	logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0] rdata_q, rdata, mask, new_word;
	logic                 rvld_q;
	scan_res_t            scan;
	logic [CNT_W-1:0]     next_pg, req_end, alloc_base;
	logic [CNT_W:0]       req_sum;
	logic                 req_fire;

	assign pready = 1'b1;
	assign prdata = {{(32-CNT_W){1'b0}}, managed_q};
	assign lim = (managed_q > MAX_PAGES) ? MAX_PAGES : managed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q <= MAX_PAGES;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			managed_q <= pwdata[CNT_W-1:0];
		end
	end

	assign req_ready = (state_q == S_IDLE) && !rsp_valid;
	assign req_fire  = req_valid && req_ready;

	// map read port, registered; unwritten words read as all used
	// the scan keeps addressing its word so the read data holds
	assign rd_addr = (state_q == S_RD || state_q == S_SCAN) ?
		pg_q[BIT_W +: WADDR_W] : wptr_q;
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[rd_addr];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[rd_addr];
		end
	end
	assign rdata = rvld_q ? rdata_q : '1;

	bpa_run_scan u_scan (
		.bits       (rdata[pg_q[BIT_W-1:CHUNK_W]*CHUNK +: CHUNK]),
		.chunk_base (pg_q),
		.lim        (lim),
		.count      (cnt_q),
		.run_in     (run_q),
		.res        (scan)
	);

	bpa_mask_gen u_mask (
		.word_idx  (wptr_q),
		.rng_start (rng_start_q),
		.rng_end   (rng_end_q),
		.mask      (mask)
	);

	assign new_word   = set_q ? (rdata | mask) : (rdata & ~mask);
	assign next_pg    = pg_q + CNT_W'(CHUNK);
	assign alloc_base = scan.run_end - cnt_q;
	assign req_sum    = {1'b0, CNT_W'(start_page)} + {1'b0, req_pages};
	assign req_end    = (req_sum > {1'b0, lim}) ? lim : req_sum[CNT_W-1:0];

	always_ff @(posedge clk) begin
		if (state_q == S_MWR) begin
			mem_q[wptr_q] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (state_q == S_MWR) begin
			vld_q[wptr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid   <= 1'b0;
			status      <= ST_OK;
			base_page   <= '0;
			pg_q        <= '0;
			run_q       <= '0;
			cnt_q       <= '0;
			rng_start_q <= '0;
			rng_end_q   <= '0;
			wptr_q      <= '0;
			set_q       <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						status    <= ST_OK;
						base_page <= '0;
						cnt_q     <= req_pages;
						if (func == FUNC_ALLOC) begin
							if (req_pages == '0 || req_pages >= lim) begin
								status    <= ST_BAD_CNT;
								rsp_valid <= 1'b1;
							end else begin
								pg_q    <= '0;
								run_q   <= '0;
								state_q <= S_RD;
							end
						end else if (func == FUNC_FREE || func == FUNC_RESERVE) begin
							set_q       <= (func == FUNC_RESERVE);
							rng_start_q <= CNT_W'(start_page);
							rng_end_q   <= req_end;
							wptr_q      <= start_page[BIT_W +: WADDR_W];
							if (CNT_W'(start_page) >= req_end) begin
								rsp_valid <= 1'b1;
							end else begin
								state_q <= S_MRD;
							end
						end else begin
							rsp_valid <= 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					run_q <= scan.run;
					if (scan.found) begin
						base_page   <= alloc_base[PAGE_W-1:0];
						set_q       <= 1'b1;
						rng_start_q <= alloc_base;
						rng_end_q   <= scan.run_end;
						wptr_q      <= alloc_base[BIT_W +: WADDR_W];
						state_q     <= S_MRD;
					end else if (scan.at_lim || next_pg >= lim) begin
						status    <= ST_NO_SPACE;
						rsp_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						pg_q <= next_pg;
						// word done: fetch the next one
						if (pg_q[BIT_W-1:CHUNK_W] == '1) begin
							state_q <= S_RD;
						end
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (CNT_W'(wptr_q) == ((rng_end_q - 1'b1) >> BIT_W)) begin
						rsp_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						wptr_q  <= wptr_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_accept_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request accepted while response pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("ready right after accept");
	a_fail_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> base_page == '0)
		else $error("failed response with nonzero base");
	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MWR) |-> (rng_end_q <= lim && rng_start_q < rng_end_q))
		else $error("mark range outside managed pages");
endmodule
